@@ hw/rtl/falc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package falc_pkg;

    typedef enum logic [1:0] {
        LVL_NORMAL = 2'd0,
        LVL_GAS    = 2'd1,
        LVL_TEMP   = 2'd2,
        LVL_FIRE   = 2'd3
    } level_t;

    // Configuration register indexes
    localparam logic [2:0] REG_GAS_WARN    = 3'd0;
    localparam logic [2:0] REG_GAS_SAFE    = 3'd1;
    localparam logic [2:0] REG_TEMP_DANGER = 3'd2;
    localparam logic [2:0] REG_TEMP_SAFE   = 3'd3;
    localparam logic [2:0] REG_GAS_HOLD    = 3'd4;
    localparam logic [2:0] REG_BUTTON_HOLD = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [11:0] GAS_WARN_RST    = 12'd1800;
    localparam logic [11:0] GAS_SAFE_RST    = 12'd700;
    localparam logic [6:0]  TEMP_DANGER_RST = 7'd40;
    localparam logic [6:0]  TEMP_SAFE_RST   = 7'd35;
    localparam logic [15:0] GAS_HOLD_RST    = 16'd5000;
    localparam logic [15:0] BUTTON_HOLD_RST = 16'd5000;

    // Door flag bit positions
    localparam int DOOR_WINDOW  = 0;
    localparam int DOOR_KITCHEN = 1;
    localparam int DOOR_EXIT    = 2;

    typedef struct packed {
        logic [11:0] gas_warn_level;
        logic [11:0] gas_safe_level;
        logic [6:0]  temp_danger_level;
        logic [6:0]  temp_safe_level;
        logic [15:0] gas_hold_ms;
        logic [15:0] button_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [11:0] gas_level;
        logic        flame_seen;
        logic        temp_ok;
        logic [7:0]  temperature;
        logic        button_down;
        logic [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        level_t      current_level;
        logic        have_previous;
        logic        fire_latch;
        logic        gas_waiting;
        logic [31:0] gas_safe_start;
        logic        button_tracking;
        logic [31:0] button_press_start;
        logic [2:0]  door_flags;
    } ctl_state_t;

    typedef struct packed {
        level_t alarm_level;
        logic   level_entered;
        logic   window_open;
        logic   kitchen_open;
        logic   exit_open;
        logic   unlock_event;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/falc_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One evaluation: button unlock, level choice, door entry actions.
module falc_eval (
    input  falc_pkg::cfg_t       cfg,
    input  falc_pkg::sample_t    sample,
    input  falc_pkg::ctl_state_t state_cur,
    output falc_pkg::ctl_state_t state_nxt,
    output falc_pkg::result_t    result
);
    import falc_pkg::*;

    logic        prev_temp;
    logic        prev_gas;
    logic        temp_hot;
    logic [31:0] btn_start;
    logic [31:0] btn_elapsed;
    logic [31:0] gas_start;
    logic [31:0] gas_elapsed;
    logic        unlock;
    logic        latch_after_unlock;
    level_t      lvl;
    logic        entered;

    always_comb
    begin
        state_nxt = state_cur;
        unlock    = 1'b0;

        // Button hold tracking, only meaningful at fire level
        btn_start   = state_cur.button_tracking ? state_cur.button_press_start : sample.now_ms;
        btn_elapsed = sample.now_ms - btn_start;
        if (state_cur.current_level != LVL_FIRE || !sample.button_down)
        begin
            state_nxt.button_tracking = 1'b0;
        end
        else
        begin
            state_nxt.button_tracking    = 1'b1;
            state_nxt.button_press_start = btn_start;
            if (btn_elapsed >= {16'd0, cfg.button_hold_ms})
            begin
                state_nxt.fire_latch      = 1'b0;
                unlock                    = 1'b1;
                state_nxt.button_tracking = 1'b0;
            end
        end
        latch_after_unlock = state_nxt.fire_latch;

        prev_temp = state_cur.have_previous && (state_cur.current_level == LVL_TEMP);
        prev_gas  = state_cur.have_previous && (state_cur.current_level == LVL_GAS);

        // Signed compare: negative readings never count as hot
        if (prev_temp)
            temp_hot = $signed({sample.temperature[7], sample.temperature})
                       > $signed({2'b00, cfg.temp_safe_level});
        else
            temp_hot = $signed({sample.temperature[7], sample.temperature})
                       >= $signed({2'b00, cfg.temp_danger_level});

        gas_start   = state_cur.gas_waiting ? state_cur.gas_safe_start : sample.now_ms;
        gas_elapsed = sample.now_ms - gas_start;

        priority if (latch_after_unlock)
        begin
            lvl = LVL_FIRE;
        end
        else if (sample.flame_seen)
        begin
            state_nxt.fire_latch = 1'b1;
            lvl                  = LVL_FIRE;
        end
        else if (sample.temp_ok && temp_hot)
        begin
            lvl = LVL_TEMP;
        end
        else if (prev_gas)
        begin
            if (sample.gas_level > cfg.gas_safe_level)
            begin
                state_nxt.gas_waiting = 1'b0;
                lvl                   = LVL_GAS;
            end
            else
            begin
                state_nxt.gas_safe_start = gas_start;
                if (gas_elapsed < {16'd0, cfg.gas_hold_ms})
                begin
                    state_nxt.gas_waiting = 1'b1;
                    lvl                   = LVL_GAS;
                end
                else
                begin
                    state_nxt.gas_waiting = 1'b0;
                    lvl                   = LVL_NORMAL;
                end
            end
        end
        else if (sample.gas_level >= cfg.gas_warn_level)
        begin
            lvl = LVL_GAS;
        end
        else
        begin
            lvl = LVL_NORMAL;
        end

        entered = !state_cur.have_previous || (lvl != state_cur.current_level);

        // Entry actions on the doors
        if (entered)
        begin
            unique case (lvl)
                LVL_NORMAL: state_nxt.door_flags = 3'b000;
                LVL_GAS:    state_nxt.door_flags[DOOR_WINDOW] = 1'b1;
                LVL_TEMP:
                begin
                    state_nxt.door_flags[DOOR_WINDOW]  = 1'b1;
                    state_nxt.door_flags[DOOR_KITCHEN] = 1'b1;
                end
                LVL_FIRE:   state_nxt.door_flags = 3'b111;
                default:    state_nxt.door_flags = 3'b111;
            endcase
        end

        state_nxt.current_level = lvl;
        state_nxt.have_previous = 1'b1;

        result.alarm_level   = lvl;
        result.level_entered = entered;
        result.window_open   = state_nxt.door_flags[DOOR_WINDOW];
        result.kitchen_open  = state_nxt.door_flags[DOOR_KITCHEN];
        result.exit_open     = state_nxt.door_flags[DOOR_EXIT];
        result.unlock_event  = unlock;
    end

endmodule

`default_nettype wire

@@ hw/rtl/fire_alarm_level_controller_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// ------    ---------  ----------------------  ------------------------------------------
// in        input      in_valid / in_stall     gas_level, flame_seen, temp_ok,
//                                              temperature, button_down, now_ms
// out       output     out_valid / out_stall   alarm_level, level_entered, window_open,
//                                              kitchen_open, exit_open, unlock_event
// cfg       input      cfg_we (no wait)        cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low. A beat is held in the input
// register; the evaluation logic then updates the controller state and the result
// register at the same edge, so the next beat already sees the new state.
// Each beat passes through the input register and then the result register.
// in_stall rises only when the input register is full and the result register is
// stalled. Reset (rst_n, asynchronous) clears the pipeline, the state and restores
// the default thresholds.
module fire_alarm_level_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [falc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [falc_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [11:0]                         gas_level,
    input  logic                                flame_seen,
    input  logic                                temp_ok,
    input  logic signed [7:0]                   temperature,
    input  logic                                button_down,
    input  logic [31:0]                         now_ms,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          alarm_level,
    output logic                                level_entered,
    output logic                                window_open,
    output logic                                kitchen_open,
    output logic                                exit_open,
    output logic                                unlock_event
);
    import falc_pkg::*;

    cfg_t       cfg_reg;
    sample_t    sample_reg;
    logic       sample_valid_reg;
    ctl_state_t state_reg;
    ctl_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;
    logic       in_take;

    // Result register can take a beat when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = sample_valid_reg && out_free;
    assign in_stall = sample_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Configuration writes; out-of-range indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gas_warn_level    <= GAS_WARN_RST;
            cfg_reg.gas_safe_level    <= GAS_SAFE_RST;
            cfg_reg.temp_danger_level <= TEMP_DANGER_RST;
            cfg_reg.temp_safe_level   <= TEMP_SAFE_RST;
            cfg_reg.gas_hold_ms       <= GAS_HOLD_RST;
            cfg_reg.button_hold_ms    <= BUTTON_HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAS_WARN:    cfg_reg.gas_warn_level    <= cfg_data[11:0];
                REG_GAS_SAFE:    cfg_reg.gas_safe_level    <= cfg_data[11:0];
                REG_TEMP_DANGER: cfg_reg.temp_danger_level <= cfg_data[6:0];
                REG_TEMP_SAFE:   cfg_reg.temp_safe_level   <= cfg_data[6:0];
                REG_GAS_HOLD:    cfg_reg.gas_hold_ms       <= cfg_data;
                REG_BUTTON_HOLD: cfg_reg.button_hold_ms    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register: hold while stalled, refill as it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (in_take)
            sample_valid_reg <= 1'b1;
        else if (advance)
            sample_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg.gas_level   <= gas_level;
            sample_reg.flame_seen  <= flame_seen;
            sample_reg.temp_ok     <= temp_ok;
            sample_reg.temperature <= temperature;
            sample_reg.button_down <= button_down;
            sample_reg.now_ms      <= now_ms;
        end
    end

    falc_eval u_eval (
        .cfg       (cfg_reg),
        .sample    (sample_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Controller state advances together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= sample_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign alarm_level   = result_reg.alarm_level;
    assign level_entered = result_reg.level_entered;
    assign window_open   = result_reg.window_open;
    assign kitchen_open  = result_reg.kitchen_open;
    assign exit_open     = result_reg.exit_open;
    assign unlock_event  = result_reg.unlock_event;

endmodule

`default_nettype wire
